### hw/rtl/mbps_pkg.sv
package mbps_pkg;

  // Default signature capacity in bytes.
  localparam int unsigned MAX_SIGNATURE_DEFAULT = 128;

  // Depths of the command queue and of the result queue.
  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned RES_FIFO_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PATTERN_LENGTH  = 2'd0,
    CFG_SEARCH_BACKWARD = 2'd1,
    CFG_USE_MASK        = 2'd2
  } cfg_idx_e;

  // Command kinds handed from the front to the back.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_e;

  // Back end sequencer states.
  typedef enum logic {
    ST_RUN     = 1'b0,
    ST_REBUILD = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [7:0] pattern_length;
    logic       search_backward;
    logic       use_mask;
  } cfg_t;

  typedef struct packed {
    cmd_e        kind;
    logic [6:0]  entry_index;
    logic [7:0]  pattern_byte;
    logic [7:0]  mask_byte;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        last_byte;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } res_t;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

endpackage

### hw/rtl/mbps_ram.sv
module mbps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mbps_fifo.sv
module mbps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/mbps_front.sv
module mbps_front #(
  parameter int unsigned MAX_SIGNATURE = mbps_pkg::MAX_SIGNATURE_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic           operation_i,
  input  logic [6:0]     entry_index_i,
  input  logic [7:0]     pattern_byte_i,
  input  logic [7:0]     mask_byte_i,
  input  logic [7:0]     data_byte_i,
  input  logic [31:0]    byte_address_i,
  input  logic           last_byte_i,
  output mbps_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i
);

  import mbps_pkg::*;

  cmd_t             cmd_in;
  logic             accept;
  logic             keep;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;

  // Classify the incoming word; loads beyond the table are dropped here.
  always_comb begin
    cmd_in.kind         = operation_i ? CMD_SCAN : CMD_LOAD;
    cmd_in.entry_index  = entry_index_i;
    cmd_in.pattern_byte = pattern_byte_i;
    cmd_in.mask_byte    = mask_byte_i;
    cmd_in.data_byte    = data_byte_i;
    cmd_in.byte_address = byte_address_i;
    cmd_in.last_byte    = last_byte_i;
  end

  assign accept = push && !full;
  assign keep   = operation_i || (32'(entry_index_i) < 32'(MAX_SIGNATURE));

  // Command queue between the front and the back.
  mbps_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && keep),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

### hw/rtl/mbps_back.sv
module mbps_back #(
  parameter int unsigned MAX_SIGNATURE = mbps_pkg::MAX_SIGNATURE_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbps_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  mbps_pkg::cfg_t cfg_i,
  input  logic           len_wr_i,
  input  logic           res_full_i,
  output logic           res_push_o,
  output mbps_pkg::res_t res_o
);

  import mbps_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SIGNATURE);
  localparam int unsigned LW = $clog2(MAX_SIGNATURE + 1);
  localparam int unsigned CW = (LW > 8) ? LW : 8;

  // Effective pattern length.
  logic [CW-1:0] len_ext;
  logic [LW-1:0] eff, eff_m1;

  assign len_ext = CW'(cfg_i.pattern_length);

  always_comb begin
    if (len_ext == '0) begin
      eff = LW'(1);
    end else if (len_ext > CW'(MAX_SIGNATURE)) begin
      eff = LW'(MAX_SIGNATURE);
    end else begin
      eff = LW'(len_ext);
    end
  end

  assign eff_m1 = eff - LW'(1);

  // Sequencer: after a length write the aligned lanes are refilled from the table.
  back_state_e   state_q, state_d;
  logic [LW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_slot_q, pend_slot_d;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    pend_slot_d = IW'(k_q);
    case (state_q)
      ST_RUN: begin
        state_d = ST_RUN;
      end
      ST_REBUILD: begin
        if (k_q < eff) begin
          pend_d = 1'b1;
          k_d    = k_q + LW'(1);
        end else begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (len_wr_i) begin
      state_d = ST_REBUILD;
      k_d     = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
  end

  // Pipeline advance: a finished result that cannot be queued holds the scan pipeline and the command queue.
  logic b_vld_q, b_last_q, b_ok_q;
  logic [31:0] b_start_q;
  logic en, scan_pop, load_pop;

  assign en        = !(b_vld_q && b_last_q && res_full_i);
  assign cmd_pop_o = cmd_valid_i && (state_q == ST_RUN) && en;
  assign scan_pop  = cmd_pop_o && (cmd_i.kind == CMD_SCAN);
  assign load_pop  = cmd_pop_o && (cmd_i.kind == CMD_LOAD);

  // Signature and mask table in natural order.
  logic [15:0] ram_rdata;
  logic [IW-1:0] ram_raddr;

  assign ram_raddr = IW'(eff_m1 - k_q);

  mbps_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SIGNATURE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_pop),
    .waddr_i (IW'(cmd_i.entry_index)),
    .wdata_i ({cmd_i.pattern_byte, cmd_i.mask_byte}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Aligned lanes: lane j holds table entry (length - 1 - j), paired with window tap j.
  logic [7:0]    sig_q [MAX_SIGNATURE];
  logic [7:0]    msk_q [MAX_SIGNATURE];
  logic          ld_hit, ld_wr;
  logic [IW-1:0] ld_slot;

  assign ld_hit  = CW'(cmd_i.entry_index) < CW'(eff);
  assign ld_wr   = load_pop && ld_hit;
  assign ld_slot = IW'(eff_m1 - LW'(cmd_i.entry_index));

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_SIGNATURE; j++) begin
      if (ld_wr && (ld_slot == IW'(j))) begin
        sig_q[j] <= cmd_i.pattern_byte;
        msk_q[j] <= cmd_i.mask_byte;
      end else if (pend_q && (pend_slot_q == IW'(j))) begin
        sig_q[j] <= ram_rdata[15:8];
        msk_q[j] <= ram_rdata[7:0];
      end
    end
  end

  // Byte window: tap 0 is the newest byte.
  logic [7:0] win_q [MAX_SIGNATURE];

  always_ff @(posedge clk_i) begin
    if (scan_pop) begin
      win_q[0] <= cmd_i.data_byte;
      for (int j = 1; j < MAX_SIGNATURE; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // First stage: byte count and match start address.
  logic [7:0] cnt_q, cnt_inc;
  logic       seen_ok;

  assign cnt_inc = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
  assign seen_ok = CW'(cnt_inc) >= CW'(eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      cnt_q   <= '0;
    end else if (en) begin
      b_vld_q <= scan_pop;
      if (scan_pop) begin
        cnt_q <= cmd_i.last_byte ? 8'd0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_pop) begin
      b_ok_q    <= seen_ok;
      b_last_q  <= cmd_i.last_byte;
      b_start_q <= cmd_i.byte_address - 32'(eff_m1);
    end
  end

  // Second stage: masked compare over all lanes.
  logic [MAX_SIGNATURE-1:0] lane_ok;
  logic                     hit;

  always_comb begin
    for (int j = 0; j < MAX_SIGNATURE; j++) begin
      lane_ok[j] = (LW'(j) >= eff) ||
                   (((win_q[j] ^ sig_q[j]) & (cfg_i.use_mask ? msk_q[j] : 8'hFF)) == 8'h00);
    end
  end

  assign hit = b_ok_q && (&lane_ok);

  // Kept match and result.
  logic        seen_q, new_seen;
  logic [31:0] kept_q, new_kept;

  assign new_seen = seen_q || hit;
  assign new_kept = (hit && (cfg_i.search_backward || !seen_q)) ? b_start_q : kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      kept_q <= '0;
    end else if (b_vld_q && en) begin
      if (b_last_q) begin
        seen_q <= 1'b0;
        kept_q <= '0;
      end else begin
        seen_q <= new_seen;
        kept_q <= new_kept;
      end
    end
  end

  assign res_push_o          = b_vld_q && b_last_q && !res_full_i;
  assign res_o.found         = new_seen;
  assign res_o.match_address = new_seen ? new_kept : 32'd0;

`ifndef ASSERT_OFF
  a_no_pop_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REBUILD) |-> !cmd_pop_o)
    else $error("command taken while lanes are refilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_slot_q) < CW'(eff)))
    else $error("refill write outside the active lanes");

  a_rebuild_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REBUILD) |-> (k_q <= eff))
    else $error("refill counter ran past the pattern length");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_last_q && res_full_i) |=> (b_vld_q && b_last_q))
    else $error("stalled result lost");
`endif

endmodule

### hw/rtl/masked_byte_pattern_search.sv
// Masked byte signature search.
// Input queue port (push/full) takes one word per cycle. A word with operation 0
// loads one signature and mask entry; a word with operation 1 scans one region
// byte, in ascending address order, with last_byte set on the region's final byte.
// The result queue port (empty/pop) returns one word per region: found and the
// start address of the first match, or of the last one when search_backward is 1.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i selecting
// pattern_length, search_backward or use_mask; cfg_ready_o is always high.
// Throughput is one word per cycle while no stall holds the pipeline: the window
// shifts and all lanes compare in parallel. A region result passes the command
// queue and the first-stage registers before it is pushed to the result queue.
// A pattern_length write refills the aligned compare lanes from the signature
// table, lane by lane up to the effective length; meanwhile no input
// word is processed and full rises once the command queue fills.
// After reset the tables are undefined until loaded, pattern_length is 1,
// use_mask is 1 and search_backward is 0. When the receiver stops popping, the
// result queue fills, the scan pipeline stalls and full rises.
module masked_byte_pattern_search #(
  parameter int unsigned MAX_SIGNATURE = mbps_pkg::MAX_SIGNATURE_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [6:0]  entry_index_i,
  input  logic [7:0]  pattern_byte_i,
  input  logic [7:0]  mask_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] byte_address_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [31:0] match_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  import mbps_pkg::*;

  // Configuration registers.
  cfg_t cfg_q, cfg_d;
  logic len_wr;

  assign cfg_ready_o = 1'b1;
  assign len_wr      = cfg_valid_i && (cfg_index_i == CFG_PATTERN_LENGTH);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH:  cfg_d.pattern_length  = cfg_data_i;
        CFG_SEARCH_BACKWARD: cfg_d.search_backward = cfg_data_i[0];
        CFG_USE_MASK:        cfg_d.use_mask        = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length  <= 8'd1;
      cfg_q.search_backward <= 1'b0;
      cfg_q.use_mask        <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accepts and classifies words into the command queue.
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  mbps_front #(
    .MAX_SIGNATURE (MAX_SIGNATURE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .pattern_byte_i (pattern_byte_i),
    .mask_byte_i    (mask_byte_i),
    .data_byte_i    (data_byte_i),
    .byte_address_i (byte_address_i),
    .last_byte_i    (last_byte_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  // Back: tables, window, compare and match tracking.
  res_t res;
  logic res_push, res_full;

  mbps_back #(
    .MAX_SIGNATURE (MAX_SIGNATURE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .len_wr_i    (len_wr),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue toward the receiver.
  logic [RES_W-1:0] res_rdata;
  res_t             res_out;

  mbps_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out         = res_t'(res_rdata);
  assign found_o         = res_out.found;
  assign match_address_o = res_out.match_address;

endmodule
